// File: src/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// shared constants and types for the binary to bcd converter pipeline
// ----------------------------------------------------------------------------
package b2bcd_pkg;

    localparam int MAX_DIGITS     = 10;
    localparam int VALUE_BITS     = 32;
    localparam int DIGIT_BITS     = 4;
    localparam int BCD_BITS       = MAX_DIGITS * DIGIT_BITS;
    localparam int BITS_PER_STAGE = 8;
    localparam int NUM_STAGES     = VALUE_BITS / BITS_PER_STAGE;

    // register indexes on the configuration port
    localparam logic CFG_IDX_ORDER = 1'b0;
    localparam logic CFG_IDX_COUNT = 1'b1;

    localparam logic [DIGIT_BITS-1:0] COUNT_RESET = 4'd10;
    localparam logic [DIGIT_BITS-1:0] COUNT_MAX   = 4'd10;

    // working word of the double-dabble shifter: bcd digits above the value
    typedef struct packed {
        logic [BCD_BITS-1:0]   bcd;
        logic [VALUE_BITS-1:0] value;
    } dabble_t;

    typedef struct packed {
        logic                  order;
        logic [DIGIT_BITS-1:0] count;
    } cfg_t;

endpackage

// File: src/binary_to_bcd_converter.sv
// ----------------------------------------------------------------------------
// binary_to_bcd_converter
// pipelined 32-bit binary to packed bcd converter with apb configuration
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one 32-bit unsigned value per item (valid/ready).
//   m_ channel returns ten packed bcd nibbles, the count of significant
//   digits and a size error flag, one result item per input item.
//   apb registers: 0x0 digit_order (bit 0), 0x4 digit_count (bits 3:0).
//   registers may be written only while no item is in flight.
// timing:
//   four double-dabble stages of eight shift steps each, then one format
//   stage; each stage, the format stage included, holds its item in a register.
//   one item is accepted every cycle while the receiver keeps up.
// reset:
//   aresetn low empties the pipeline, digit_order returns to 0 and
//   digit_count to 10.
// stall:
//   when m_ready is low the pipeline fills its empty stages, then s_ready
//   drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [b2bcd_pkg::VALUE_BITS-1:0]     s_binary_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [b2bcd_pkg::BCD_BITS-1:0]       m_bcd_digits,
    output logic [b2bcd_pkg::DIGIT_BITS-1:0]     m_significant_digits,
    output logic                                 m_size_error
);

    localparam int N = b2bcd_pkg::NUM_STAGES;

    b2bcd_pkg::cfg_t    cfg_reg;
    logic               cfg_write;
    logic               valid_w [N+1];
    logic               ready_w [N+1];
    b2bcd_pkg::dabble_t data_w  [N+1];

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.order <= 1'b0;
            cfg_reg.count <= b2bcd_pkg::COUNT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                b2bcd_pkg::CFG_IDX_ORDER: cfg_reg.order <= pwdata[0];
                b2bcd_pkg::CFG_IDX_COUNT: cfg_reg.count <= pwdata[b2bcd_pkg::DIGIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            b2bcd_pkg::CFG_IDX_ORDER: prdata = {31'd0, cfg_reg.order};
            b2bcd_pkg::CFG_IDX_COUNT: prdata = {28'd0, cfg_reg.count};
            default:                  prdata = '0;
        endcase
    end

    // pipeline entry: empty bcd digits above the value
    assign valid_w[0]      = s_valid;
    assign s_ready         = ready_w[0];
    assign data_w[0].bcd   = '0;
    assign data_w[0].value = s_binary_value;

    // double-dabble stages
    for (genvar g = 0; g < N; g++) begin : g_stage
        b2bcd_dd_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[g]),
            .in_ready  (ready_w[g]),
            .in_data   (data_w[g]),
            .out_valid (valid_w[g+1]),
            .out_ready (ready_w[g+1]),
            .out_data  (data_w[g+1])
        );
    end

    // format and output stage
    b2bcd_format u_format (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg_reg),
        .in_valid             (valid_w[N]),
        .in_ready             (ready_w[N]),
        .in_bcd               (data_w[N].bcd),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bcd_digits         (m_bcd_digits),
        .m_significant_digits (m_significant_digits),
        .m_size_error         (m_size_error)
    );

endmodule

// File: src/b2bcd_dd_stage.sv
// ----------------------------------------------------------------------------
// b2bcd_dd_stage
// one pipeline stage of double dabble: eight shift-and-correct steps
// ----------------------------------------------------------------------------
module b2bcd_dd_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  b2bcd_pkg::dabble_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output b2bcd_pkg::dabble_t out_data
);

    logic               valid_reg;
    b2bcd_pkg::dabble_t data_reg;
    b2bcd_pkg::dabble_t data_next;

    // add 3 to every digit of 5 or more, then shift in the next value bit
    always_comb begin
        b2bcd_pkg::dabble_t work;
        work = in_data;
        for (int i = 0; i < b2bcd_pkg::BITS_PER_STAGE; i++) begin
            for (int d = 0; d < b2bcd_pkg::MAX_DIGITS; d++) begin
                if (work.bcd[d*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS] >= 4'd5) begin
                    work.bcd[d*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS] =
                        work.bcd[d*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS] + 4'd3;
                end
            end
            work = b2bcd_pkg::dabble_t'({work.bcd, work.value} << 1);
        end
        data_next = work;
    end

    // stage advances when empty or when the next stage takes its item
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/b2bcd_format.sv
// ----------------------------------------------------------------------------
// b2bcd_format
// output stage: digit count, size check and digit placement
// ----------------------------------------------------------------------------
module b2bcd_format (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  b2bcd_pkg::cfg_t                      cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [b2bcd_pkg::BCD_BITS-1:0]       in_bcd,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [b2bcd_pkg::BCD_BITS-1:0]       m_bcd_digits,
    output logic [b2bcd_pkg::DIGIT_BITS-1:0]     m_significant_digits,
    output logic                                 m_size_error
);

    logic                                valid_reg;
    logic [b2bcd_pkg::BCD_BITS-1:0]      digits_reg;
    logic [b2bcd_pkg::BCD_BITS-1:0]      digits_next;
    logic [b2bcd_pkg::DIGIT_BITS-1:0]    sig_reg;
    logic [b2bcd_pkg::DIGIT_BITS-1:0]    sig_next;
    logic                                err_reg;
    logic                                err_next;
    logic [b2bcd_pkg::DIGIT_BITS-1:0]    count;
    logic [b2bcd_pkg::DIGIT_BITS-1:0]    dig [b2bcd_pkg::MAX_DIGITS];

    // split into digits, clamp the position count
    always_comb begin
        for (int d = 0; d < b2bcd_pkg::MAX_DIGITS; d++) begin
            dig[d] = in_bcd[d*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS];
        end
        count = (cfg.count > b2bcd_pkg::COUNT_MAX) ? b2bcd_pkg::COUNT_MAX : cfg.count;
    end

    // significant digits: one above the highest nonzero digit
    always_comb begin
        sig_next = '0;
        for (int d = 0; d < b2bcd_pkg::MAX_DIGITS; d++) begin
            if (dig[d] != '0) begin
                sig_next = b2bcd_pkg::DIGIT_BITS'(d + 1);
            end
        end
        err_next = (sig_next > count);
    end

    // place the low count digits in the selected order
    always_comb begin
        logic [b2bcd_pkg::DIGIT_BITS-1:0] k;
        logic [b2bcd_pkg::DIGIT_BITS-1:0] jj;
        digits_next = '0;
        for (int j = 0; j < b2bcd_pkg::MAX_DIGITS; j++) begin
            jj = b2bcd_pkg::DIGIT_BITS'(j);
            k  = cfg.order ? jj : (count - 4'd1 - jj);
            if (jj < count) begin
                digits_next[j*b2bcd_pkg::DIGIT_BITS +: b2bcd_pkg::DIGIT_BITS] = dig[k];
            end
        end
    end

    // output register doubles as the result channel
    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            digits_reg <= digits_next;
            sig_reg    <= sig_next;
            err_reg    <= err_next;
        end
    end

    assign m_valid              = valid_reg;
    assign m_bcd_digits         = digits_reg;
    assign m_significant_digits = sig_reg;
    assign m_size_error         = err_reg;

endmodule
